/* sv/dfupk_pkg.sv */
package dfupk_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    localparam int unsigned SUFFIX_LEN  = 12;
    localparam int unsigned TRAILER_LEN = 16;
    localparam int unsigned TRL_CNT_W   = 4;

    // configuration register indexes
    localparam logic REG_SFX_EN  = 1'b0;
    localparam logic REG_PKT_LEN = 1'b1;

    localparam logic        SFX_EN_RST  = 1'b1;
    localparam logic [15:0] PKT_LEN_RST = 16'd2048;

    // one entry of the front-to-back queue
    typedef struct packed {
        logic [7:0]  data;
        logic        pend;
        logic        last;
        logic        trailer;
        logic [31:0] crc;
    } q_entry_t;

    typedef struct packed {
        logic                 busy;
        logic [TRL_CNT_W-1:0] cnt;
        logic                 load;
    } back_status_t;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h000000, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // DFU suffix: FF FF FF FF AC 05 00 01 55 46 44 10
    function automatic logic [7:0] suffix_byte(input logic [TRL_CNT_W-1:0] idx);
        logic [7:0] v;
        case (idx)
            4'd0, 4'd1, 4'd2, 4'd3: v = 8'hFF;
            4'd4:    v = 8'hAC;
            4'd5:    v = 8'h05;
            4'd6:    v = 8'h00;
            4'd7:    v = 8'h01;
            4'd8:    v = 8'h55;
            4'd9:    v = 8'h46;
            4'd10:   v = 8'h44;
            4'd11:   v = 8'h10;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

/* sv/dfupk_front.sv */
module dfupk_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               sfx_en,
    input  logic [15:0]        pkt_len,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               s_final_byte,
    input  logic               q_full,
    output logic               q_push,
    output dfupk_pkg::q_entry_t q_entry
);
    import dfupk_pkg::*;

    logic [31:0] crc_reg, crc_next;
    logic [15:0] bip_reg, bip_next;
    logic [16:0] fill;
    logic [17:0] fill_trl;
    logic        full;
    logic        own;
    logic [31:0] crc_upd;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    always_comb begin
        fill     = {1'b0, bip_reg} + 17'd1;
        fill_trl = {1'b0, fill} + 18'(TRAILER_LEN);
        full     = fill >= {1'b0, pkt_len};
        own      = fill_trl > {2'b00, pkt_len};
        crc_upd  = crc32_byte(crc_reg, s_data_byte);

        q_entry.data    = s_data_byte;
        q_entry.crc     = crc_upd;
        q_entry.trailer = 1'b0;
        q_entry.pend    = full;
        q_entry.last    = 1'b1;
        crc_next        = crc_reg;
        bip_next        = bip_reg;

        if (q_push) begin
            if (!s_final_byte) begin
                crc_next = crc_upd;
                bip_next = full ? 16'd0 : fill[15:0];
            end else begin
                crc_next = CRC_INIT;
                bip_next = 16'd0;
                if (sfx_en) begin
                    q_entry.pend    = own;
                    q_entry.last    = 1'b0;
                    q_entry.trailer = 1'b1;
                end else begin
                    q_entry.pend = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_INIT;
            bip_reg <= 16'd0;
        end else begin
            crc_reg <= crc_next;
            bip_reg <= bip_next;
        end
    end

endmodule

/* sv/dfupk_queue.sv */
module dfupk_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  dfupk_pkg::q_entry_t        wr_entry,
    input  logic                       pop,
    output dfupk_pkg::q_entry_t        head,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    import dfupk_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    q_entry_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full  = cnt_reg == CNT_W'(DEPTH);
    assign empty = cnt_reg == '0;
    assign count = cnt_reg;
    assign head  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* sv/dfupk_back.sv */
module dfupk_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  dfupk_pkg::q_entry_t     head,
    input  logic                    q_empty,
    output logic                    q_pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [7:0]              m_out_byte,
    output logic                    m_packet_end,
    output logic                    m_run_last,
    output dfupk_pkg::back_status_t status
);
    import dfupk_pkg::*;

    logic                 busy_reg, busy_next;
    logic [TRL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]          crc_reg, crc_next;
    logic                 valid_reg, valid_next;
    logic [7:0]           byte_reg, byte_next;
    logic                 pend_reg, pend_next;
    logic                 last_reg, last_next;
    logic                 load;
    logic [7:0]           sfx;
    logic [TRL_CNT_W-1:0] crc_idx;

    assign load  = !valid_reg || m_ready;
    assign q_pop = load && !busy_reg && !q_empty;

    always_comb begin
        sfx        = suffix_byte(cnt_reg);
        crc_idx    = cnt_reg - TRL_CNT_W'(SUFFIX_LEN);
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        crc_next   = crc_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        pend_next  = pend_reg;
        last_next  = last_reg;

        if (load) begin
            if (busy_reg) begin
                valid_next = 1'b1;
                if (cnt_reg < TRL_CNT_W'(SUFFIX_LEN)) begin
                    byte_next = sfx;
                    crc_next  = crc32_byte(crc_reg, sfx);
                end else begin
                    byte_next = crc_reg[{crc_idx[1:0], 3'b000} +: 8];
                end
                pend_next = cnt_reg == TRL_CNT_W'(TRAILER_LEN - 1);
                last_next = cnt_reg == TRL_CNT_W'(TRAILER_LEN - 1);
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == TRL_CNT_W'(TRAILER_LEN - 1)) begin
                    busy_next = 1'b0;
                end
            end else if (!q_empty) begin
                valid_next = 1'b1;
                byte_next  = head.data;
                pend_next  = head.pend;
                last_next  = head.last;
                if (head.trailer) begin
                    busy_next = 1'b1;
                    cnt_next  = '0;
                    crc_next  = head.crc;
                end
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg  <= crc_next;
        byte_reg <= byte_next;
        pend_reg <= pend_next;
        last_reg <= last_next;
    end

    assign m_valid      = valid_reg;
    assign m_out_byte   = byte_reg;
    assign m_packet_end = pend_reg;
    assign m_run_last   = last_reg;

    assign status.busy = busy_reg;
    assign status.cnt  = cnt_reg;
    assign status.load = load;

endmodule

/* sv/dfu_packetizer_crc32_trailer.sv */
// channel   ports                                        direction
// input     s_valid s_ready s_data_byte s_final_byte     in
// result    m_valid m_ready m_out_byte m_packet_end      out
//           m_run_last
// config    cfg_wr_en cfg_index cfg_wdata                in (write only)
//
// One byte per cycle in and out, unless the queue is full or m_ready is low;
// the output register sets the rate. A final byte in DFU mode gives 17 result
// items; the input keeps filling the QUEUE_DEPTH-entry queue meanwhile.
// From input accept to result, a byte passes the queue memory, then the output register.
// Reset is synchronous, active low: suffix on, packet length 2048, queue empty.
module dfu_packetizer_crc32_trailer #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_final_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_packet_end,
    output logic        m_run_last
);
    import dfupk_pkg::*;

    localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

    logic         sfx_en_reg;
    logic [15:0]  pkt_len_reg;
    logic         q_push, q_pop, q_full, q_empty;
    q_entry_t     q_wr, q_head;
    logic [QCNT_W-1:0] q_count;
    back_status_t bk_status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sfx_en_reg  <= SFX_EN_RST;
            pkt_len_reg <= PKT_LEN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SFX_EN:  sfx_en_reg  <= cfg_wdata[0];
                REG_PKT_LEN: pkt_len_reg <= cfg_wdata;
                default:     sfx_en_reg  <= sfx_en_reg;
            endcase
        end
    end

    dfupk_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .sfx_en       (sfx_en_reg),
        .pkt_len      (pkt_len_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_final_byte (s_final_byte),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_entry      (q_wr)
    );

    dfupk_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_entry (q_wr),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty),
        .count    (q_count)
    );

    dfupk_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (q_head),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_packet_end (m_packet_end),
        .m_run_last   (m_run_last),
        .status       (bk_status)
    );

    // a result item that is not the last of its run belongs to a running trailer
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_run_last |-> bk_status.busy)
        else $error("trailer not running under a non-final result item");

    // last trailer byte loaded ends the trailer
    assert property (@(posedge aclk) disable iff (!aresetn)
        bk_status.busy && bk_status.load && bk_status.cnt == TRL_CNT_W'(TRAILER_LEN - 1)
        |=> !bk_status.busy)
        else $error("trailer did not end after sixteen bytes");

    assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // nothing leaves the queue while the trailer is being sent
    assert property (@(posedge aclk) disable iff (!aresetn)
        bk_status.busy |-> !q_pop)
        else $error("queue popped during trailer");

endmodule
